FILE: rtl/aabb_all_pairs_overlap_assert.svh
// ----------------------------------------------------------------------------
// aabb assertion macros
// shared concurrent assertion forms, clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef AABB_ALL_PAIRS_OVERLAP_ASSERT_SVH
`define AABB_ALL_PAIRS_OVERLAP_ASSERT_SVH

// same-cycle implication
`define AABB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AABB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// shared constants, types and the overlap test for the box broad phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aabb_pkg;

    localparam int MAX_BOXES   = 64;
    localparam int COORD_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_BOXES);
    localparam int CNT_W       = $clog2(MAX_BOXES + 1);
    localparam int IDX_OUT_W   = 6;
    localparam int BOX_W       = 6 * COORD_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OVF
    } state_t;

    // touching boxes count as overlapping
    function automatic logic boxes_overlap(input box_t a, input box_t b);
        logic sep;
        sep = (a.max_x < b.min_x) || (b.max_x < a.min_x)
           || (a.max_y < b.min_y) || (b.max_y < a.min_y)
           || (a.max_z < b.min_z) || (b.max_z < a.min_z);
        return !sep;
    endfunction

endpackage

FILE: rtl/aabb_box_if.sv
// ----------------------------------------------------------------------------
// aabb_box_if
// input channel: one box per transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aabb_box_if import aabb_pkg::*; ();

    logic   valid;
    logic   ready;
    logic   start_new_set;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;

    modport source (
        output valid, start_new_set, min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );

    modport sink (
        input  valid, start_new_set, min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );

endinterface

FILE: rtl/aabb_pair_if.sv
// ----------------------------------------------------------------------------
// aabb_pair_if
// output channel: one overlapping pair or overflow mark per transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aabb_pair_if import aabb_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] first_index;
    logic [IDX_OUT_W-1:0] second_index;
    logic                 last_of_run;
    logic                 overflow;

    modport source (
        output valid, first_index, second_index, last_of_run, overflow,
        input  ready
    );

    modport sink (
        input  valid, first_index, second_index, last_of_run, overflow,
        output ready
    );

endinterface

FILE: rtl/aabb_ram.sv
// ----------------------------------------------------------------------------
// aabb_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/aabb_all_pairs_overlap.sv
// ----------------------------------------------------------------------------
// aabb_all_pairs_overlap
// incremental all-pairs broad phase over 3d boxes held in one box ram
// ----------------------------------------------------------------------------
// channel | dir | payload                                          | handshake
// box     | in  | start_new_set, min_x..min_z, max_x..max_z        | valid/ready
// pair    | out | first_index, second_index, last_of_run, overflow | valid/ready
//
// a box with n stored boxes before it goes through: accept, n reads of the box
// ram at one entry per cycle unless a stalled pair output holds the scan, the
// last compare on the registered read data, a check that the scan is done, then
// the write-back of the new box. an overflow box only sends the overflow mark.
// reset empties the store; ram contents are not cleared.
// a stalled pair output pauses the scan while a second hit waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_all_pairs_overlap import aabb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    aabb_box_if.sink    box,
    aabb_pair_if.source pair
);

`include "aabb_all_pairs_overlap_assert.svh"

    state_t               state_reg, state_next;
    box_t                 box_reg, box_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_OUT_W-1:0] out_first_reg, out_first_next;
    logic [IDX_OUT_W-1:0] out_second_reg, out_second_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 accept;
    logic                 out_free;
    logic                 hit;
    logic                 scan_done;
    logic                 advance;
    logic [CNT_W-1:0]     count_eff;
    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    box_t                 ram_rdata;

    assign accept    = box.valid && box.ready;
    assign out_free  = !out_valid_reg || pair.ready;
    assign hit       = cmp_valid_reg && boxes_overlap(ram_rdata, box_reg);
    assign scan_done = !cmp_valid_reg && (scan_idx_reg == count_reg);
    // a second hit needs the held one pushed out first
    assign advance   = !(hit && pend_valid_reg && !out_free);
    assign count_eff = box.start_new_set ? '0 : count_reg;

    aabb_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (box_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (count_eff >= CNT_W'(MAX_BOXES))
                        state_next = ST_OVF;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            end
            ST_OVF:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        box.ready       = 1'b0;
        box_next        = box_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !pair.ready;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = scan_idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                box.ready = 1'b1;
                if (accept)
                begin
                    box_next.min_x  = box.min_x;
                    box_next.min_y  = box.min_y;
                    box_next.min_z  = box.min_z;
                    box_next.max_x  = box.max_x;
                    box_next.max_y  = box.max_y;
                    box_next.max_z  = box.max_z;
                    count_next      = count_eff;
                    scan_idx_next   = '0;
                    cmp_valid_next  = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    if (scan_idx_reg < count_reg)
                    begin
                        ram_re         = 1'b1;
                        scan_idx_next  = scan_idx_reg + CNT_W'(1);
                        cmp_valid_next = 1'b1;
                        cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        cmp_valid_next = 1'b0;
                    end
                    if (hit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_idx_next   = cmp_idx_reg;
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_first_next  = IDX_OUT_W'(pend_idx_reg);
                            out_second_next = IDX_OUT_W'(count_reg);
                            out_last_next   = 1'b0;
                            out_ovf_next    = 1'b0;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (pend_valid_reg)
                    begin
                        pend_valid_next = 1'b0;
                        out_valid_next  = 1'b1;
                        out_first_next  = IDX_OUT_W'(pend_idx_reg);
                        out_second_next = IDX_OUT_W'(count_reg);
                        out_last_next   = 1'b1;
                        out_ovf_next    = 1'b0;
                    end
                end
            end
            ST_OVF:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_first_next  = '0;
                    out_second_next = '0;
                    out_last_next   = 1'b1;
                    out_ovf_next    = 1'b1;
                end
            end
            default:
            begin
                box.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg        <= box_next;
        cmp_idx_reg    <= cmp_idx_next;
        pend_idx_reg   <= pend_idx_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_last_reg   <= out_last_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign pair.valid        = out_valid_reg;
    assign pair.first_index  = out_first_reg;
    assign pair.second_index = out_second_reg;
    assign pair.last_of_run  = out_last_reg;
    assign pair.overflow     = out_ovf_reg;

    `AABB_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_BOXES), "box count past capacity")
    `AABB_ASSERT_NOW(a_ram_excl, ram_we, !ram_re, "box ram read during write-back")
    `AABB_ASSERT_NOW(a_ovf_shape, out_valid_reg && out_ovf_reg,
        out_last_reg && (out_first_reg == '0) && (out_second_reg == '0), "bad overflow result")
    `AABB_ASSERT_NEXT(a_idle_clean, accept, !pend_valid_reg && !cmp_valid_reg,
        "stale scan state after box accept")

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// regression for the incremental box broad phase: boxes go in on the box
// channel, a scoreboard predicts every overlapping pair and overflow mark,
// and each pair transaction is checked in order against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import aabb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = MAX_BOXES + 8;
    localparam int MAX_PRINTED    = 100;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] first_index;
        logic [IDX_OUT_W-1:0] second_index;
        logic                 last_of_run;
        logic                 overflow;
    } overlap_pair_t;

    logic clk = 1'b0;
    logic rst_n;

    aabb_box_if  box_ch ();
    aabb_pair_if pair_ch ();

    aabb_all_pairs_overlap i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .box   (box_ch),
        .pair  (pair_ch)
    );

    // scoreboard copy of the box store
    box_t          held_boxes [MAX_BOXES];
    int            held_count;
    overlap_pair_t expected_pairs [$];

    int   mismatch_count;
    int   idle_cycles;
    bit   idling_on;
    int   long_hold_left;
    int   sink_stall_left;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    function automatic logic boxes_touch(input box_t a, input box_t b);
        logic apart;
        apart = (a.max_x < b.min_x) || (b.max_x < a.min_x)
             || (a.max_y < b.min_y) || (b.max_y < a.min_y)
             || (a.max_z < b.min_z) || (b.max_z < a.min_z);
        return !apart;
    endfunction

    // expected pairs for one accepted box, then the box joins the store
    task automatic predict_pairs(input logic start, input box_t b);
        overlap_pair_t r;
        int            hits;
        hits = 0;
        if (start)
        begin
            held_count = 0;
        end
        if (held_count >= MAX_BOXES)
        begin
            r.first_index  = '0;
            r.second_index = '0;
            r.last_of_run  = 1'b1;
            r.overflow     = 1'b1;
            expected_pairs.push_back(r);
            return;
        end
        for (int i = 0; i < held_count; i++)
        begin
            if (boxes_touch(held_boxes[i], b))
            begin
                r.first_index  = IDX_OUT_W'(i);
                r.second_index = IDX_OUT_W'(held_count);
                r.last_of_run  = 1'b0;
                r.overflow     = 1'b0;
                expected_pairs.push_back(r);
                hits++;
            end
        end
        if (hits > 0)
        begin
            expected_pairs[expected_pairs.size() - 1].last_of_run = 1'b1;
        end
        held_boxes[held_count] = b;
        held_count++;
    endtask

    function automatic box_t make_box(input int mnx, input int mny, input int mnz,
                                      input int mxx, input int mxy, input int mxz);
        box_t b;
        b.min_x = coord_t'(mnx);
        b.min_y = coord_t'(mny);
        b.min_z = coord_t'(mnz);
        b.max_x = coord_t'(mxx);
        b.max_y = coord_t'(mxy);
        b.max_z = coord_t'(mxz);
        return b;
    endfunction

    function automatic box_t make_cube(input int lo, input int hi);
        return make_box(lo, lo, lo, hi, hi, hi);
    endfunction

    // clustered span in q16.16 so that overlaps are common
    function automatic logic [63:0] random_span();
        int centre;
        int half;
        centre = ($urandom_range(0, 2000) - 1000) * 4096 + $urandom_range(0, 4095);
        half   = $urandom_range(0, 600) * 4096 + $urandom_range(0, 4095);
        return {32'(centre - half), 32'(centre + half)};
    endfunction

    function automatic box_t random_box();
        box_t        b;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] sz;
        int          pick;
        int          base;
        int          width;
        pick = $urandom_range(0, 9);
        if (pick == 9 && held_count > 0)
        begin
            // shifted copy of a stored box that touches it or misses by one lsb
            b     = held_boxes[$urandom_range(0, held_count - 1)];
            width = $urandom_range(0, 65536);
            case ($urandom_range(0, 2))
                0:
                begin
                    base    = int'(b.max_x) + $urandom_range(0, 1);
                    b.min_x = coord_t'(base);
                    b.max_x = coord_t'(base + width);
                end
                1:
                begin
                    base    = int'(b.max_y) + $urandom_range(0, 1);
                    b.min_y = coord_t'(base);
                    b.max_y = coord_t'(base + width);
                end
                default:
                begin
                    base    = int'(b.max_z) + $urandom_range(0, 1);
                    b.min_z = coord_t'(base);
                    b.max_z = coord_t'(base + width);
                end
            endcase
        end
        else if (pick >= 7)
        begin
            b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            if (pick == 8)
            begin
                // near full-range span on x
                b.min_x = coord_t'(32'h8000_0000 | ($urandom & 32'h0000_ffff));
                b.max_x = coord_t'(32'h7fff_0000 | ($urandom & 32'h0000_ffff));
            end
        end
        else
        begin
            sx = random_span();
            sy = random_span();
            sz = random_span();
            b.min_x = coord_t'(sx[63:32]);
            b.max_x = coord_t'(sx[31:0]);
            b.min_y = coord_t'(sy[63:32]);
            b.max_y = coord_t'(sy[31:0]);
            b.min_z = coord_t'(sz[63:32]);
            b.max_z = coord_t'(sz[31:0]);
        end
        return b;
    endfunction

    // offer one box and hold it until the transaction completes
    task automatic send_box(input logic start, input box_t b);
        int gap;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            box_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        box_ch.valid         <= 1'b1;
        box_ch.start_new_set <= start;
        box_ch.min_x         <= b.min_x;
        box_ch.min_y         <= b.min_y;
        box_ch.min_z         <= b.min_z;
        box_ch.max_x         <= b.max_x;
        box_ch.max_y         <= b.max_y;
        box_ch.max_z         <= b.max_z;
        do
        begin
            @(posedge clk);
        end
        while (box_ch.ready !== 1'b1);
        predict_pairs(start, b);
    endtask

    task automatic release_box_channel();
        @(negedge clk);
        box_ch.valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        // full-range box, then point boxes at both extreme corners
        send_box(1'b1, make_cube(32'h8000_0000, 32'h7fff_ffff));
        send_box(1'b0, make_cube(32'h8000_0000, 32'h8000_0000));
        send_box(1'b0, make_cube(32'h7fff_ffff, 32'h7fff_ffff));
        send_box(1'b0, make_cube(0, 32'h0001_0000));
        // touching on x, then one lsb apart on x
        send_box(1'b0, make_box(32'h0001_0000, 0, 0, 32'h0002_0000, 32'h0001_0000,
                                32'h0001_0000));
        send_box(1'b0, make_box(32'h0002_0001, 0, 0, 32'h0003_0000, 32'h0001_0000,
                                32'h0001_0000));
        // fresh set: touching and missing on y below and z above, missing on x from both sides
        send_box(1'b1, make_cube(0, 32'h0001_0000));
        send_box(1'b0, make_box(0, -32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0001_0000));
        send_box(1'b0, make_box(0, -32'h0002_0000, 0, 32'h0001_0000, -1, 32'h0001_0000));
        send_box(1'b0, make_box(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                32'h0002_0000));
        send_box(1'b0, make_box(0, 0, 32'h0002_0001, 32'h0001_0000, 32'h0001_0000,
                                32'h0003_0000));
        send_box(1'b0, make_box(-32'h0002_0000, 0, 0, -1, 32'h0001_0000, 32'h0001_0000));
        send_box(1'b0, make_box(32'h0001_0001, 0, 0, 32'h0002_0000, 32'h0001_0000,
                                32'h0001_0000));
        // inverted boxes, plain and at the extremes
        send_box(1'b0, make_cube(32'h0000_8000, 32'h0000_4000));
        send_box(1'b0, make_cube(32'h7fff_ffff, 32'h8000_0000));
        send_box(1'b0, make_box(32'h0000_8000, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
        // a set whose boxes never meet
        send_box(1'b1, make_cube(32'h1000_0000, 32'h1000_ffff));
        send_box(1'b0, make_cube(-32'h1000_0000, -32'h0fff_0000));
        send_box(1'b0, make_cube(32'h7000_0000, 32'h7fff_ffff));
        send_box(1'b0, make_cube(32'h8000_0000, 32'h8fff_ffff));
    endtask

    task automatic test_store_overflow();
        send_box(1'b1, random_box());
        for (int k = 1; k < MAX_BOXES; k++)
        begin
            send_box(1'b0, random_box());
        end
        // store full: dropped boxes, the last one overlaps everything
        send_box(1'b0, random_box());
        send_box(1'b0, make_cube(32'h8000_0000, 32'h7fff_ffff));
        // a new set clears the full store
        send_box(1'b1, make_cube(32'h8000_0000, 32'h7fff_ffff));
        send_box(1'b0, random_box());
    endtask

    task automatic test_random_sets(input int n_items);
        int sent;
        int set_len;
        sent = 0;
        while (sent < n_items)
        begin
            set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12);
            for (int k = 0; k < set_len && sent < n_items; k++)
            begin
                send_box(k == 0 || $urandom_range(0, 29) == 0, random_box());
                sent++;
            end
        end
    endtask

    // long receiver hold-off while boxes that all overlap keep arriving
    task automatic test_output_backpressure();
        long_hold_left = 400;
        send_box(1'b1, make_cube(32'h8000_0000, 32'h7fff_ffff));
        for (int k = 0; k < 14; k++)
        begin
            send_box(1'b0, make_cube(-32'h0001_0000 - k, 32'h0001_0000 + k));
        end
    endtask

    task automatic test_unpaced_run();
        idling_on = 1'b0;
        test_random_sets(10);
    endtask

    // pair side: ready with random stalls, plus the long hold-off
    initial
    begin
        pair_ch.ready   = 1'b0;
        long_hold_left  = 0;
        sink_stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                pair_ch.ready <= 1'b0;
            end
            else if (sink_stall_left > 0)
            begin
                sink_stall_left--;
                pair_ch.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                sink_stall_left = $urandom_range(1, 10) - 1;
                pair_ch.ready <= 1'b0;
            end
            else
            begin
                pair_ch.ready <= 1'b1;
            end
        end
    end

    // result checking and watchdog
    initial
    begin
        overlap_pair_t got;
        overlap_pair_t want;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pair_ch.valid === 1'b1 && pair_ch.ready === 1'b1)
            begin
                got.first_index  = pair_ch.first_index;
                got.second_index = pair_ch.second_index;
                got.last_of_run  = pair_ch.last_of_run;
                got.overflow     = pair_ch.overflow;
                if (expected_pairs.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pair %0d,%0d last=%b ovf=%b",
                                              got.first_index, got.second_index,
                                              got.last_of_run, got.overflow));
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (got.first_index !== want.first_index
                        || got.second_index !== want.second_index
                        || got.last_of_run !== want.last_of_run
                        || got.overflow !== want.overflow)
                    begin
                        report_mismatch($sformatf(
                            "pair got %0d,%0d last=%b ovf=%b want %0d,%0d last=%b ovf=%b",
                            got.first_index, got.second_index, got.last_of_run,
                            got.overflow, want.first_index, want.second_index,
                            want.last_of_run, want.overflow));
                    end
                end
            end
            if ((pair_ch.valid === 1'b1 && pair_ch.ready === 1'b1)
                || (box_ch.valid === 1'b1 && box_ch.ready === 1'b1))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("aabb_all_pairs_overlap regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        box_ch.valid         = 1'b0;
        box_ch.start_new_set = 1'b0;
        box_ch.min_x         = '0;
        box_ch.min_y         = '0;
        box_ch.min_z         = '0;
        box_ch.max_x         = '0;
        box_ch.max_y         = '0;
        box_ch.max_z         = '0;
        held_count           = 0;
        mismatch_count       = 0;
        idling_on            = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_store_overflow();
        test_random_sets(12);
        test_output_backpressure();
        test_unpaced_run();
        release_box_channel();

        while (expected_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("aabb_all_pairs_overlap regression: pass");
        end
        else
        begin
            $display("aabb_all_pairs_overlap regression: fail");
        end
        $finish;
    end

endmodule

FILE: aabb_all_pairs_overlap.f
+incdir+rtl
rtl/aabb_pkg.sv
rtl/aabb_box_if.sv
rtl/aabb_pair_if.sv
rtl/aabb_ram.sv
rtl/aabb_all_pairs_overlap.sv
sim/tb_top.sv
